>>> rtl/core/lru_key_value_cache_defines.svh
// Assertion helpers for the LRU key/value cache. Every property is clocked on
// the rising edge of clock and is switched off while reset is high.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_key_value_cache: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lru_key_value_cache: next-cycle check failed");

`endif

>>> rtl/core/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 31;
   localparam int RESULT_W   = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Operation codes carried in the action field.
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // Register map (byte addresses).
   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   // Returned on a get miss and on every put.
   localparam logic signed [RESULT_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic                       found;
      logic signed [RESULT_W-1:0] read_value;
   } result_type;

endpackage

>>> rtl/core/lkv_channels.sv
`timescale 1ns / 1ps

// Request channel: one get or put per transfer.
interface lkv_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [lkv_pkg::KEY_W-1:0]   key;
   logic [lkv_pkg::VALUE_W-1:0] value;

   modport source (output valid, output action, output key, output value, input ready);
   modport sink   (input valid, input action, input key, input value, output ready);
endinterface

// Response channel: one result per request.
interface lkv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic signed [lkv_pkg::RESULT_W-1:0] read_value;

   modport source (output valid, output found, output read_value, input ready);
   modport sink   (input valid, input found, input read_value, output ready);
endinterface

>>> rtl/core/lkv_store.sv
`timescale 1ns / 1ps

// Entry storage with parallel key match, recency ranks and occupancy count.
// The result for the presented item is combinational; state updates on the
// clock edge at which access_en is high.
module lkv_store #(
   parameter int ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  access_en,
   input  lkv_pkg::item_type                     item,
   input  logic [lkv_pkg::CAP_W-1:0]             capacity,
   output lkv_pkg::result_type                   result,
   output logic [$clog2(ENTRIES+1)-1:0]          occupancy
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

   logic [lkv_pkg::KEY_W-1:0]   key_ff   [ENTRIES];
   logic [lkv_pkg::VALUE_W-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]           rank_ff  [ENTRIES];
   logic [ENTRIES-1:0]          valid_ff;
   logic [CNT_W-1:0]            occ_ff;

   logic [ENTRIES-1:0]          hit_oh;
   logic [ENTRIES-1:0]          victim_oh;
   logic [ENTRIES-1:0]          free_oh;
   logic [ENTRIES-1:0]          target_oh;
   logic [lkv_pkg::VALUE_W-1:0] hit_value;
   logic [RANK_W-1:0]           hit_rank;
   logic [CMP_W-1:0]            cap_ext;
   logic [CMP_W-1:0]            eff_cap;
   logic [CNT_W-1:0]            threshold;
   logic                        hit;
   logic                        is_put;
   logic                        do_fill;
   logic                        update;

   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]    = valid_ff[i] && (key_ff[i] == item.key);
         victim_oh[i] = valid_ff[i] && (CNT_W'(rank_ff[i]) == occ_ff - 1'b1);
         hit_value    = hit_value | (value_ff[i] & {lkv_pkg::VALUE_W{hit_oh[i]}});
         hit_rank     = hit_rank | (rank_ff[i] & {RANK_W{hit_oh[i]}});
      end
   end

   // Lowest free slot, isolated as the lowest set bit of the free mask.
   assign free_oh = ~valid_ff & (valid_ff + 1'b1);

   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (capacity == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign hit     = |hit_oh;
   assign is_put  = (item.action == lkv_pkg::ACTION_PUT);
   assign do_fill = is_put && !hit && (CMP_W'(occ_ff) < eff_cap);
   assign update  = access_en && (hit || is_put);

   // Entries ranked below the threshold age by one; the target becomes rank 0.
   always_comb begin
      priority if (hit) begin
         target_oh = hit_oh;
         threshold = CNT_W'(hit_rank);
      end else if (do_fill) begin
         target_oh = free_oh;
         threshold = occ_ff;
      end else begin
         target_oh = victim_oh;
         threshold = occ_ff - 1'b1;
      end
   end

   always_comb begin
      result.found = hit;
      if (!is_put && hit) begin
         result.read_value = $signed({1'b0, hit_value});
      end else begin
         result.read_value = lkv_pkg::MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (update) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (target_oh[i]) begin
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && (CNT_W'(rank_ff[i]) < threshold)) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
         end
         if (access_en && do_fill) begin
            valid_ff <= valid_ff | free_oh;
            occ_ff   <= occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (access_en && is_put) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (target_oh[i]) begin
               key_ff[i]   <= item.key;
               value_ff[i] <= item.value;
            end
         end
      end
   end

   assign occupancy = occ_ff;

endmodule

>>> rtl/core/lru_key_value_cache.sv
// LRU key/value cache. A fully associative store of up to ENTRIES 32-bit keys,
// each holding a 31-bit value, replaced in least-recently-used order. A get
// (action 0) returns found and the stored value on a hit, or found 0 and -1 on
// a miss; a hit makes the entry the most recent. A put (action 1) always
// returns -1, with found telling whether the key was already present; it
// overwrites a present key, fills a free entry while fewer than capacity
// entries are in use, and otherwise silently evicts the least recent entry.
// The store is empty after reset. Each request passes an input register and a
// result register; the response is offered once the staged request has been
// processed into the result register. One request per cycle is sustained
// while rsp_bus.ready stays high; the rate is set by the parallel key
// compare and rank update over all entries. The capacity register (byte
// address 0, reset 16, zero read as one, values above ENTRIES read as ENTRIES)
// may only be written while no request is in flight.
`timescale 1ns / 1ps
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   lkv_req_if.sink                          req_bus,
   lkv_rsp_if.source                        rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Input stage: holds one accepted request until the store consumes it.
   logic                      stage_valid_ff;
   logic                      stage_valid_in;
   lkv_pkg::item_type         stage_item_ff;

   // Output stage: holds one result until the response transfer.
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   lkv_pkg::result_type       rsp_result_ff;

   logic [lkv_pkg::CAP_W-1:0] capacity_ff;
   logic [lkv_pkg::CAP_W-1:0] capacity_in;

   lkv_pkg::result_type       store_result;
   logic [CNT_W-1:0]          occupancy;
   logic                      advance;
   logic                      req_fire;
   logic                      csr_write;

   // The staged request is processed whenever the result register is free or
   // is being emptied in the same cycle.
   assign advance       = stage_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == lkv_pkg::REG_CAPACITY_ADDR);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == lkv_pkg::REG_CAPACITY_ADDR)
                       ? lkv_pkg::CSR_DATA_W'(capacity_ff) : '0;

   always_comb begin
      stage_valid_in = req_bus.ready ? req_bus.valid : stage_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      capacity_in = csr_write ? csr_pwdata[lkv_pkg::CAP_W-1:0] : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         capacity_ff    <= lkv_pkg::CAPACITY_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         capacity_ff    <= capacity_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_item_ff.action <= req_bus.action;
         stage_item_ff.key    <= req_bus.key;
         stage_item_ff.value  <= req_bus.value;
      end
      if (advance) begin
         rsp_result_ff <= store_result;
      end
   end

   lkv_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .access_en (advance),
      .item      (stage_item_ff),
      .capacity  (capacity_ff),
      .result    (store_result),
      .occupancy (occupancy)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = rsp_result_ff.found;
   assign rsp_bus.read_value = rsp_result_ff.read_value;

   // Occupancy never exceeds the number of physical entries.
   `LKV_ASSERT_NOW(a_occ_bound, 1'b1, occupancy <= CNT_W'(ENTRIES))

   // Occupancy moves only on a processed request, and then by at most one.
   `LKV_ASSERT_NEXT(a_occ_idle, !advance, $stable(occupancy))
   `LKV_ASSERT_NEXT(a_occ_step, advance,
      (occupancy == $past(occupancy)) || (occupancy == $past(occupancy) + 1'b1))

   // A processed put always yields a pending result carrying the miss value.
   `LKV_ASSERT_NEXT(a_put_result, advance && (stage_item_ff.action == lkv_pkg::ACTION_PUT),
      rsp_valid_ff && (rsp_result_ff.read_value == lkv_pkg::MISS_VALUE))

endmodule
